>>> hw/rtl/fmce_pkg.sv
// ----------------------------------------------------------------------------
// fmce_pkg
// shared types and constants of the framed motor command encoder unit
// ----------------------------------------------------------------------------
package fmce_pkg;

  localparam int unsigned FRAME_DEPTH_DEFAULT = 16;

  localparam logic [7:0] OWN_ADDRESS_RESET = 8'h65;
  localparam logic [15:0] PWM_PERIOD_RESET = 16'd1024;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic [0:0] REG_OWN_ADDRESS = 1'b0;
  localparam logic [0:0] REG_PWM_PERIOD  = 1'b1;

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_DRIVE  = 2'd2;

  localparam logic [1:0] DIR_OFF  = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;

  typedef enum logic [2:0] {
    CMD_CLEAR, CMD_REPORT, CMD_LEFT, CMD_RIGHT, CMD_BOTH, CMD_BRAKE
  } cmd_t;

  // one queued job: either an encoder sample or a closed frame command
  typedef struct packed {
    logic       enc;
    logic [3:0] phases;
    cmd_t       cmd;
    logic [7:0] l_sign;
    logic [7:0] l_d0, l_d1, l_d2, l_d3, l_d4;
    logic [7:0] r_sign;
    logic [7:0] r_d0, r_d1, r_d2, r_d3, r_d4;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  echo_char;
    logic [31:0] left_position;
    logic [31:0] right_position;
    logic [15:0] left_duty;
    logic [1:0]  left_dir;
    logic [15:0] right_duty;
    logic [1:0]  right_dir;
    logic        last;
  } result_t;

endpackage

>>> hw/rtl/fmce_front.sv
// ----------------------------------------------------------------------------
// fmce_front
// gathers frame bytes and turns closed frames and encoder samples into jobs
// ----------------------------------------------------------------------------
module fmce_front #(
  parameter int unsigned FRAME_DEPTH = fmce_pkg::FRAME_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           func,
  input  logic [7:0]     rx_byte,
  input  logic [3:0]     phases,
  input  logic [7:0]     own_address,
  output logic           job_valid,
  output fmce_pkg::job_t job
);

  localparam int unsigned IW = $clog2(FRAME_DEPTH + 1);

  logic          in_frame;
  logic [IW-1:0] frame_index;
  logic [7:0]    frame_bytes [FRAME_DEPTH];
  logic          cmd_ok;
  fmce_pkg::cmd_t cmd;

  always_comb begin
    cmd_ok = 1'b1;
    cmd = fmce_pkg::CMD_CLEAR;
    case (frame_bytes[3])
      fmce_pkg::CH_ZERO: cmd = fmce_pkg::CMD_CLEAR;
      fmce_pkg::CH_P:    cmd = fmce_pkg::CMD_REPORT;
      fmce_pkg::CH_L:    cmd = fmce_pkg::CMD_LEFT;
      fmce_pkg::CH_R:    cmd = fmce_pkg::CMD_RIGHT;
      fmce_pkg::CH_U:    cmd = fmce_pkg::CMD_BOTH;
      fmce_pkg::CH_S:    cmd = fmce_pkg::CMD_BRAKE;
      default:           cmd_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && !func && in_frame && rx_byte != fmce_pkg::CH_CLOSE &&
        frame_index < IW'(FRAME_DEPTH))
      frame_bytes[frame_index[$clog2(FRAME_DEPTH)-1:0]] <= rx_byte;
    job.enc    <= func;
    job.phases <= phases;
    job.cmd    <= cmd;
    job.l_sign <= frame_bytes[4];
    job.l_d0   <= frame_bytes[5];
    job.l_d1   <= frame_bytes[6];
    job.l_d2   <= frame_bytes[7];
    job.l_d3   <= frame_bytes[8];
    job.l_d4   <= frame_bytes[9];
    job.r_sign <= frame_bytes[10];
    job.r_d0   <= frame_bytes[11];
    job.r_d1   <= frame_bytes[12];
    job.r_d2   <= frame_bytes[13];
    job.r_d3   <= frame_bytes[14];
    job.r_d4   <= frame_bytes[15];
    if (rst) begin
      in_frame    <= 1'b0;
      frame_index <= '0;
      job_valid   <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (in_valid) begin
        if (func) begin
          job_valid <= 1'b1;
        end else if (!in_frame) begin
          if (rx_byte == fmce_pkg::CH_OPEN) begin
            in_frame    <= 1'b1;
            frame_index <= '0;
          end
        end else if (rx_byte == fmce_pkg::CH_CLOSE) begin
          in_frame    <= 1'b0;
          frame_index <= '0;
          job_valid   <= cmd_ok && frame_bytes[0] == own_address;
        end else if (frame_index < IW'(FRAME_DEPTH)) begin
          frame_index <= frame_index + 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/fmce_queue.sv
// ----------------------------------------------------------------------------
// fmce_queue
// small first-in first-out store of jobs between front and back
// ----------------------------------------------------------------------------
module fmce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  fmce_pkg::job_t wdata,
  input  logic           rd,
  output logic           nempty,
  output logic [2:0]     count,
  output fmce_pkg::job_t rdata
);

  fmce_pkg::job_t mem [4];
  logic [1:0] wp, rp;

  assign nempty = count != 3'd0;
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

>>> hw/rtl/fmce_back.sv
// ----------------------------------------------------------------------------
// fmce_back
// executes jobs: encoder counting, speed parsing, drive registers, results
// ----------------------------------------------------------------------------
module fmce_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  fmce_pkg::job_t    job,
  output logic              job_take,
  input  logic [15:0]       pwm_period,
  output logic              res_valid,
  output fmce_pkg::result_t res,
  input  logic              res_take
);

  typedef enum logic [2:0] {
    S_IDLE, S_SPEED, S_APPLY, S_OUT
  } state_t;

  state_t state;
  fmce_pkg::job_t cur;
  logic [31:0] left_count, right_count;
  logic left_prev_a, right_prev_a;
  logic [15:0] duty [2];
  logic [1:0]  dir [2];
  logic [15:0] echo_duty [2];
  logic [1:0]  echo_dir [2];
  logic signed [31:0] lv, rv;
  logic [31:0] lmag, rmag;
  logic [1:0] nres, ridx;
  logic [1:0] kinds [3];
  logic [15:0] limit;
  logic signed [31:0] lsum, rsum;

  function automatic logic signed [31:0] dsum(input logic [7:0] a, b, c, d, e);
    dsum = ($signed({24'd0, a}) - 32'sd48) * 32'sd10000
         + ($signed({24'd0, b}) - 32'sd48) * 32'sd1000
         + ($signed({24'd0, c}) - 32'sd48) * 32'sd100
         + ($signed({24'd0, d}) - 32'sd48) * 32'sd10
         + ($signed({24'd0, e}) - 32'sd48);
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    mag = v < 0 ? 32'(-v) : 32'(v);
  endfunction

  assign limit = pwm_period == 16'd0 ? 16'd0 : pwm_period - 16'd1;
  assign lsum = dsum(cur.l_d0, cur.l_d1, cur.l_d2, cur.l_d3, cur.l_d4);
  assign rsum = dsum(cur.r_d0, cur.r_d1, cur.r_d2, cur.r_d3, cur.r_d4);
  assign lmag = mag(lv);
  assign rmag = mag(rv);
  assign job_take = state == S_IDLE && job_valid;

  // the echo beat carries the drive as it stood before the command
  always_comb begin
    res.kind = kinds[ridx];
    res.echo_char = res.kind == fmce_pkg::KIND_ECHO ?
                    (cur.cmd == fmce_pkg::CMD_LEFT ? fmce_pkg::CH_L : fmce_pkg::CH_U) : 8'd0;
    res.left_position  = res.kind == fmce_pkg::KIND_REPORT ? left_count : 32'd0;
    res.right_position = res.kind == fmce_pkg::KIND_REPORT ? right_count : 32'd0;
    res.left_duty  = res.kind == fmce_pkg::KIND_ECHO ? echo_duty[0] : duty[0];
    res.left_dir   = res.kind == fmce_pkg::KIND_ECHO ? echo_dir[0] : dir[0];
    res.right_duty = res.kind == fmce_pkg::KIND_ECHO ? echo_duty[1] : duty[1];
    res.right_dir  = res.kind == fmce_pkg::KIND_ECHO ? echo_dir[1] : dir[1];
    res.last = ridx == nres - 2'd1;
  end
  assign res_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left_count <= '0;
      right_count <= '0;
      left_prev_a <= 1'b0;
      right_prev_a <= 1'b0;
      duty[0] <= '0;
      duty[1] <= '0;
      dir[0] <= fmce_pkg::DIR_OFF;
      dir[1] <= fmce_pkg::DIR_OFF;
      ridx <= '0;
      nres <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            ridx <= '0;
            if (job.enc) begin
              if (job.phases[0] != left_prev_a)
                left_count <= left_count + ((job.phases[1] != job.phases[0]) ?
                              32'd1 : 32'hFFFF_FFFF);
              left_prev_a <= job.phases[0];
              if (job.phases[2] != right_prev_a)
                right_count <= right_count + ((job.phases[3] == job.phases[2]) ?
                               32'd1 : 32'hFFFF_FFFF);
              right_prev_a <= job.phases[2];
            end else begin
              case (job.cmd)
                fmce_pkg::CMD_CLEAR: begin
                  left_count <= '0;
                  right_count <= '0;
                end
                fmce_pkg::CMD_REPORT: begin
                  kinds[0] <= fmce_pkg::KIND_REPORT;
                  nres <= 2'd1;
                  state <= S_OUT;
                end
                fmce_pkg::CMD_BRAKE: begin
                  dir[0] <= fmce_pkg::DIR_OFF;
                  dir[1] <= fmce_pkg::DIR_OFF;
                  duty[0] <= limit;
                  duty[1] <= limit;
                  kinds[0] <= fmce_pkg::KIND_DRIVE;
                  kinds[1] <= fmce_pkg::KIND_REPORT;
                  nres <= 2'd2;
                  state <= S_OUT;
                end
                default: state <= S_SPEED;
              endcase
            end
          end
        end
        S_SPEED: begin
          lv <= cur.l_sign == fmce_pkg::CH_MINUS ? -lsum : lsum;
          rv <= cur.r_sign == fmce_pkg::CH_MINUS ? -rsum : rsum;
          echo_duty[0] <= duty[0];
          echo_duty[1] <= duty[1];
          echo_dir[0] <= dir[0];
          echo_dir[1] <= dir[1];
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (cur.cmd != fmce_pkg::CMD_RIGHT && lv != 0) begin
            dir[0] <= lv > 0 ? fmce_pkg::DIR_FWD : fmce_pkg::DIR_BACK;
            duty[0] <= lmag > {16'd0, limit} ? limit : lmag[15:0];
          end
          if (cur.cmd == fmce_pkg::CMD_RIGHT && lv != 0) begin
            dir[1] <= lv > 0 ? fmce_pkg::DIR_FWD : fmce_pkg::DIR_BACK;
            duty[1] <= lmag > {16'd0, limit} ? limit : lmag[15:0];
          end
          if (cur.cmd == fmce_pkg::CMD_BOTH && rv != 0) begin
            dir[1] <= rv > 0 ? fmce_pkg::DIR_FWD : fmce_pkg::DIR_BACK;
            duty[1] <= rmag > {16'd0, limit} ? limit : rmag[15:0];
          end
          case (cur.cmd)
            fmce_pkg::CMD_LEFT: begin
              kinds[0] <= fmce_pkg::KIND_ECHO;
              kinds[1] <= fmce_pkg::KIND_DRIVE;
              nres <= 2'd2;
            end
            fmce_pkg::CMD_RIGHT: begin
              kinds[0] <= fmce_pkg::KIND_DRIVE;
              nres <= 2'd1;
            end
            default: begin
              kinds[0] <= fmce_pkg::KIND_ECHO;
              kinds[1] <= fmce_pkg::KIND_DRIVE;
              kinds[2] <= fmce_pkg::KIND_REPORT;
              nres <= 2'd3;
            end
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_take) begin
            ridx <= ridx + 2'd1;
            if (res.last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/fmce_outq.sv
// ----------------------------------------------------------------------------
// fmce_outq
// two-entry result buffer facing the consumer
// ----------------------------------------------------------------------------
module fmce_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  fmce_pkg::result_t wdata,
  output logic              can_wr,
  input  logic              rd,
  output logic              nempty,
  output fmce_pkg::result_t rdata
);

  fmce_pkg::result_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign can_wr = count != 2'd2;
  assign nempty = count != 2'd0;
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> hw/rtl/framed_motor_command_encoder_unit.sv
// ----------------------------------------------------------------------------
// framed_motor_command_encoder_unit
// A front stage takes one item per cycle while full is low, gathers frame
// bytes and queues encoder samples and addressed frame commands; the back
// stage executes one queued job at a time. Encoder samples and the other
// commands execute in the idle state; left, right and both commands pass
// through the speed and apply states of the back sequencer first, and results
// leave one beat at a time. full rises while the job queue has little room left.
// ----------------------------------------------------------------------------
module framed_motor_command_encoder_unit #(
  parameter int unsigned FRAME_DEPTH = fmce_pkg::FRAME_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  input  logic        left_phase_a,
  input  logic        left_phase_b,
  input  logic        right_phase_a,
  input  logic        right_phase_b,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  echo_char,
  output logic signed [31:0] left_position,
  output logic signed [31:0] right_position,
  output logic [15:0] left_duty,
  output logic [1:0]  left_dir,
  output logic [15:0] right_duty,
  output logic [1:0]  right_dir,
  output logic        last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  own_address;
  logic [15:0] pwm_period;
  logic        job_valid, job_take, q_nempty, b_valid, o_can, o_nempty;
  logic [2:0]  q_count;
  fmce_pkg::job_t    job, q_job;
  fmce_pkg::result_t b_res, o_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= fmce_pkg::OWN_ADDRESS_RESET;
      pwm_period  <= fmce_pkg::PWM_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fmce_pkg::REG_OWN_ADDRESS: own_address <= cfg_data[7:0];
        fmce_pkg::REG_PWM_PERIOD:  pwm_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // room for one job in flight in the front register
  assign full = q_count >= 3'd3;

  fmce_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk, .rst,
    .in_valid(push && !full), .func, .rx_byte,
    .phases({right_phase_b, right_phase_a, left_phase_b, left_phase_a}),
    .own_address, .job_valid, .job
  );

  fmce_queue u_queue (
    .clk, .rst, .wr(job_valid), .wdata(job), .rd(job_take),
    .nempty(q_nempty), .count(q_count), .rdata(q_job)
  );

  fmce_back u_back (
    .clk, .rst, .job_valid(q_nempty), .job(q_job), .job_take,
    .pwm_period, .res_valid(b_valid), .res(b_res), .res_take(b_valid && o_can)
  );

  fmce_outq u_outq (
    .clk, .rst, .wr(b_valid && o_can), .wdata(b_res), .can_wr(o_can),
    .rd(pop && o_nempty), .nempty(o_nempty), .rdata(o_res)
  );

  assign empty = !o_nempty;
  assign kind = o_res.kind;
  assign echo_char = o_res.echo_char;
  assign left_position = o_res.left_position;
  assign right_position = o_res.right_position;
  assign left_duty = o_res.left_duty;
  assign left_dir = o_res.left_dir;
  assign right_duty = o_res.right_duty;
  assign right_dir = o_res.right_dir;
  assign last = o_res.last;

endmodule
